[src/menger_4d_fold_step_unit_macros.svh]
// Assertion macros for the 4D fold step unit.
`ifndef MENGER_4D_FOLD_STEP_UNIT_MACROS_SVH
`define MENGER_4D_FOLD_STEP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MFS_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication check failed");
`define MFS_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define MFS_ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define MFS_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

[src/mfs_pkg.sv]
// Shared types, constants and saturation helpers of the 4D fold step unit.
package mfs_pkg;

  localparam int P_W                   = 32;
  localparam int D_W                   = 31;
  localparam int SCALE_W               = 21;
  localparam int RSQ_W                 = 31;
  localparam int CFG_DATA_W            = 32;
  localparam int CFG_IDX_W             = 3;
  localparam int DEFAULT_FRACTION_BITS = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE     = 3'd0,
    CFG_OFFSET_X  = 3'd1,
    CFG_OFFSET_Y  = 3'd2,
    CFG_OFFSET_Z  = 3'd3,
    CFG_OFFSET_W  = 3'd4,
    CFG_MIN_RSQ   = 3'd5,
    CFG_MAX_RSQ   = 3'd6,
    CFG_SPHERE_ON = 3'd7
  } cfg_idx_t;

  localparam logic [SCALE_W-1:0] SCALE_RST    = 21'd196608;
  localparam logic [P_W-1:0]     OFFSET_X_RST = 32'd65536;
  localparam logic [P_W-1:0]     OFFSET_Y_RST = 32'd65536;
  localparam logic [P_W-1:0]     OFFSET_Z_RST = 32'd32768;
  localparam logic [P_W-1:0]     OFFSET_W_RST = 32'd65536;
  localparam logic [RSQ_W-1:0]   MIN_RSQ_RST  = 31'd16384;
  localparam logic [RSQ_W-1:0]   MAX_RSQ_RST  = 31'd65536;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [P_W-1:0]     offset_x;
    logic [P_W-1:0]     offset_y;
    logic [P_W-1:0]     offset_z;
    logic [P_W-1:0]     offset_w;
    logic [RSQ_W-1:0]   min_radius_sq;
    logic [RSQ_W-1:0]   max_radius_sq;
    logic               sphere_fold_on;
  } mfs_cfg_t;

  typedef struct packed {
    logic [P_W-1:0] x;
    logic [P_W-1:0] y;
    logic [P_W-1:0] z;
    logic [P_W-1:0] w;
    logic [D_W-1:0] deriv;
  } mfs_item_t;

  function automatic logic [P_W-1:0] sat_s32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat_s32 = {1'b0, {(P_W-1){1'b1}}};
    end else if (v < lo) begin
      sat_s32 = {1'b1, {(P_W-1){1'b0}}};
    end else begin
      sat_s32 = v[P_W-1:0];
    end
  endfunction

  function automatic logic [D_W-1:0] sat_d(input logic signed [63:0] v);
    logic signed [63:0] hi;
    hi = 64'sd2147483647;
    if (v > hi) begin
      sat_d = {D_W{1'b1}};
    end else if (v < 64'sd0) begin
      sat_d = '0;
    end else begin
      sat_d = v[D_W-1:0];
    end
  endfunction

endpackage

[src/mfs_if.sv]
// Valid/ready channel interfaces for points in and folded points out.
interface mfs_in_if import mfs_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [P_W-1:0] in_x;
  logic [P_W-1:0] in_y;
  logic [P_W-1:0] in_z;
  logic [P_W-1:0] in_w;
  logic [D_W-1:0] in_deriv;

  modport source (output valid, in_x, in_y, in_z, in_w, in_deriv, input ready);
  modport sink (input valid, in_x, in_y, in_z, in_w, in_deriv, output ready);
endinterface

interface mfs_out_if import mfs_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [P_W-1:0] out_x;
  logic [P_W-1:0] out_y;
  logic [P_W-1:0] out_z;
  logic [P_W-1:0] out_w;
  logic [D_W-1:0] out_deriv;

  modport source (output valid, out_x, out_y, out_z, out_w, out_deriv, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, out_deriv, output ready);
endinterface

[src/mfs_tdiv.sv]
// Serial divider for the z fold plane, one quotient bit per cycle.
module mfs_tdiv import mfs_pkg::*; #(
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS,
  localparam int T_W = P_W + FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic [SCALE_W-1:0] scale,
  input  logic [P_W-1:0]     offset_z,
  output logic               busy,
  output logic [T_W-1:0]     t
);

  localparam int DV_W  = P_W + FRACTION_BITS;
  localparam int DS_W  = SCALE_W + 1;
  localparam int CNT_W = $clog2(DV_W + 1);

  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DS_W-1:0]  rem_r, rem_nxt;
  logic [DV_W-1:0]  dv_r, dv_nxt;
  logic [DS_W-1:0]  div_r, div_nxt;
  logic             neg_r, neg_nxt;
  logic             zero_r, zero_nxt;
  logic [DS_W:0]    r2;
  logic             ge;
  logic [P_W-1:0]   mag;

  always_comb begin
    mag      = offset_z[P_W-1] ? (~offset_z + 1'b1) : offset_z;
    r2       = {rem_r, dv_r[DV_W-1]};
    ge       = r2 >= {1'b0, div_r};
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    if (pend_r) begin
      pend_nxt = 1'b0;
      cnt_nxt  = CNT_W'(DV_W);
      rem_nxt  = '0;
      dv_nxt   = {mag, {FRACTION_BITS{1'b0}}};
      div_nxt  = {scale, 1'b0};
      neg_nxt  = offset_z[P_W-1];
      zero_nxt = (scale == '0);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      rem_nxt = ge ? DS_W'(r2 - {1'b0, div_r}) : DS_W'(r2);
      dv_nxt  = {dv_r[DV_W-2:0], ge};
    end
    if (load) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b1;
      cnt_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dv_r   <= dv_nxt;
    div_r  <= div_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

  assign busy = pend_r || (cnt_r != '0);
  assign t    = zero_r ? '0 : (neg_r ? T_W'(~dv_r + 1'b1) : T_W'(dv_r));

endmodule

[src/mfs_fold.sv]
// Abs, sorting network, z fold and scale/offset stages of the fold step.
module mfs_fold import mfs_pkg::*; #(
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS,
  localparam int T_W = P_W + FRACTION_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  mfs_item_t      in_item,
  input  mfs_cfg_t       cfg,
  input  logic [T_W-1:0] t,
  output logic           out_valid,
  output mfs_item_t      out_item
);

  localparam int PM_W = P_W + SCALE_W;
  localparam int ZD_W = T_W + 2;

  typedef logic [3:0][P_W-1:0] quad_t;

  function automatic quad_t cswap(input quad_t v, input int i, input int j);
    quad_t o;
    o = v;
    if (v[i] < v[j]) begin
      o[i] = v[j];
      o[j] = v[i];
    end
    return o;
  endfunction

  function automatic logic [P_W-1:0] absv(input logic [P_W-1:0] v);
    return v[P_W-1] ? (~v + 1'b1) : v;
  endfunction

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  quad_t          a1_r, a2_r, a3_r, s2, s3;
  logic [D_W-1:0] d1_r, d2_r, d3_r, d4_r;

  logic [P_W-1:0]         p0_4_r, p1_4_r, p3_4_r, zf4_r;
  logic signed [ZD_W-1:0] two_t, zdiff, zmin;
  logic signed [63:0]     zmin64;

  logic [PM_W-1:0]        m0_r, m1_r, m3_r;
  logic signed [PM_W:0]   mz_r;
  logic [D_W+SCALE_W-1:0] md_r;

  logic signed [63:0] sx, sy, sw, sz, sd;
  mfs_item_t          out_r;

  always_comb begin
    s2 = cswap(cswap(cswap(a1_r, 0, 1), 0, 2), 1, 2);
    s3 = cswap(cswap(cswap(a2_r, 0, 3), 1, 3), 2, 3);
  end

  always_comb begin
    two_t  = $signed({t[T_W-1], t, 1'b0});
    zdiff  = two_t - $signed(ZD_W'(a3_r[2]));
    zmin   = ($signed(ZD_W'(a3_r[2])) < zdiff) ? $signed(ZD_W'(a3_r[2])) : zdiff;
    zmin64 = 64'(zmin);
  end

  always_comb begin
    sx = $signed(64'(m0_r >> FRACTION_BITS)) - 64'($signed(cfg.offset_x));
    sy = $signed(64'(m1_r >> FRACTION_BITS)) - 64'($signed(cfg.offset_y));
    sw = $signed(64'(m3_r >> FRACTION_BITS)) - 64'($signed(cfg.offset_w));
    sz = 64'(mz_r >>> FRACTION_BITS);
    sd = $signed(64'(md_r >> FRACTION_BITS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= {absv(in_item.w), absv(in_item.z), absv(in_item.y), absv(in_item.x)};
      d1_r   <= in_item.deriv;
      a2_r   <= s2;
      d2_r   <= d1_r;
      a3_r   <= s3;
      d3_r   <= d2_r;
      p0_4_r <= a3_r[0];
      p1_4_r <= a3_r[1];
      p3_4_r <= a3_r[3];
      zf4_r  <= sat_s32(zmin64);
      d4_r   <= d3_r;
      m0_r   <= p0_4_r * cfg.scale;
      m1_r   <= p1_4_r * cfg.scale;
      m3_r   <= p3_4_r * cfg.scale;
      mz_r   <= $signed(zf4_r) * $signed({1'b0, cfg.scale});
      md_r   <= d4_r * cfg.scale;
      out_r  <= '{x: sat_s32(sx), y: sat_s32(sy), z: sat_s32(sz), w: sat_s32(sw),
                  deriv: sat_d(sd)};
    end
  end

  assign out_valid = v6_r;
  assign out_item  = out_r;

endmodule

[src/mfs_sphere.sv]
// Sphere fold: radius, factor select and a pipelined restoring divider per lane.
module mfs_sphere import mfs_pkg::*; #(
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  mfs_item_t in_item,
  input  mfs_cfg_t  cfg,
  output logic      out_valid,
  output mfs_item_t out_item
);

  localparam int SQ_W      = 2 * P_W;
  localparam int RR_W      = SQ_W - FRACTION_BITS;
  localparam int PR_W      = P_W + RSQ_W;
  localparam int QB        = P_W + 1;
  localparam int REM_W     = RSQ_W;
  localparam int LANES     = 5;
  localparam int DIV_STEPS = QB;

  localparam logic [QB-1:0] Q_POS_MAX = QB'((64'd1 << (P_W - 1)) - 64'd1);
  localparam logic [QB-1:0] Q_NEG_MAX = QB'(64'd1 << (P_W - 1));
  localparam logic [QB-1:0] Q_D_MAX   = QB'((64'd1 << D_W) - 64'd1);

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QB-1:0]    pq;
    logic             ovf;
    logic             neg;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] ln;
    logic [REM_W-1:0]  den;
    logic              fold;
    mfs_item_t         item;
  } dstage_t;

  function automatic logic [P_W-1:0] absv(input logic [P_W-1:0] v);
    return v[P_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic dstage_t div_step(input dstage_t s);
    dstage_t        o;
    logic [REM_W:0] r2;
    logic           ge;
    o = s;
    for (int i = 0; i < LANES; i++) begin
      r2 = {s.ln[i].rem, s.ln[i].pq[QB-1]};
      ge = r2 >= {1'b0, s.den};
      o.ln[i].rem = ge ? REM_W'(r2 - {1'b0, s.den}) : REM_W'(r2);
      o.ln[i].pq  = {s.ln[i].pq[QB-2:0], ge};
    end
    return o;
  endfunction

  function automatic logic [P_W-1:0] fin_pt(input lane_t l);
    logic [P_W-1:0] r;
    if (l.neg) begin
      if (l.ovf || l.pq > Q_NEG_MAX) begin
        r = {1'b1, {(P_W-1){1'b0}}};
      end else begin
        r = P_W'(QB'(0) - l.pq);
      end
    end else begin
      if (l.ovf || l.pq > Q_POS_MAX) begin
        r = {1'b0, {(P_W-1){1'b1}}};
      end else begin
        r = P_W'(l.pq);
      end
    end
    return r;
  endfunction

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [DIV_STEPS:0] dval_r;

  logic [3:0][SQ_W-1:0] sq1_r;
  logic [1:0][SQ_W:0]   s2_r;
  logic [RR_W-1:0]      rr3_r;
  logic [REM_W-1:0]     den4_r, den5_r;
  logic                 fold4_r, fold5_r;
  mfs_item_t            it1_r, it2_r, it3_r, it4_r, it5_r;

  logic [LANES-1:0][PR_W-1:0] pr5_r;
  logic [LANES-1:0]           neg5_r;
  logic [LANES-1:0][P_W-1:0]  lmag;

  logic [SQ_W+1:0] sum3;
  logic [SQ_W-1:0] sum3_sat;
  logic            lt_min, lt_max;

  dstage_t   ds_r [DIV_STEPS+1];
  dstage_t   ds0;
  dstage_t   dlast;
  mfs_item_t fin;
  mfs_item_t out_r;
  logic      out_v_r;

  always_comb begin
    sum3     = (SQ_W+2)'(s2_r[0]) + (SQ_W+2)'(s2_r[1]);
    sum3_sat = (sum3[SQ_W+1:SQ_W] != 2'b00) ? {SQ_W{1'b1}} : sum3[SQ_W-1:0];
    lt_min   = rr3_r < RR_W'(cfg.min_radius_sq);
    lt_max   = rr3_r < RR_W'(cfg.max_radius_sq);
    lmag     = {P_W'(it4_r.deriv), absv(it4_r.w), absv(it4_r.z), absv(it4_r.y),
                absv(it4_r.x)};
  end

  always_comb begin
    ds0.den  = den5_r;
    ds0.fold = fold5_r;
    ds0.item = it5_r;
    for (int i = 0; i < LANES; i++) begin
      ds0.ln[i].rem = REM_W'(pr5_r[i][PR_W-1:QB]);
      ds0.ln[i].pq  = pr5_r[i][QB-1:0];
      ds0.ln[i].ovf = REM_W'(pr5_r[i][PR_W-1:QB]) >= den5_r;
      ds0.ln[i].neg = neg5_r[i];
    end
  end

  always_comb begin
    dlast = ds_r[DIV_STEPS];
    fin   = dlast.item;
    if (dlast.fold) begin
      fin.x     = fin_pt(dlast.ln[0]);
      fin.y     = fin_pt(dlast.ln[1]);
      fin.z     = fin_pt(dlast.ln[2]);
      fin.w     = fin_pt(dlast.ln[3]);
      fin.deriv = (dlast.ln[4].ovf || dlast.ln[4].pq > Q_D_MAX) ? {D_W{1'b1}} :
                  D_W'(dlast.ln[4].pq);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      dval_r  <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v1_r    <= in_valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      dval_r  <= {dval_r[DIV_STEPS-1:0], v5_r};
      out_v_r <= dval_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq1_r[0] <= absv(in_item.x) * absv(in_item.x);
      sq1_r[1] <= absv(in_item.y) * absv(in_item.y);
      sq1_r[2] <= absv(in_item.z) * absv(in_item.z);
      sq1_r[3] <= absv(in_item.w) * absv(in_item.w);
      it1_r    <= in_item;
      s2_r[0]  <= (SQ_W+1)'(sq1_r[0]) + (SQ_W+1)'(sq1_r[1]);
      s2_r[1]  <= (SQ_W+1)'(sq1_r[2]) + (SQ_W+1)'(sq1_r[3]);
      it2_r    <= it1_r;
      rr3_r    <= RR_W'(sum3_sat >> FRACTION_BITS);
      it3_r    <= it2_r;
      fold4_r  <= cfg.sphere_fold_on && (lt_min || lt_max);
      den4_r   <= lt_min ? cfg.min_radius_sq :
                  ((rr3_r == '0) ? REM_W'(1) : rr3_r[REM_W-1:0]);
      it4_r    <= it3_r;
      for (int i = 0; i < LANES; i++) begin
        pr5_r[i] <= lmag[i] * cfg.max_radius_sq;
      end
      neg5_r   <= {1'b0, it4_r.w[P_W-1], it4_r.z[P_W-1], it4_r.y[P_W-1],
                   it4_r.x[P_W-1]};
      den5_r   <= den4_r;
      fold5_r  <= fold4_r;
      it5_r    <= it4_r;
      ds_r[0]  <= ds0;
      out_r    <= fin;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        ds_r[k] <= div_step(ds_r[k-1]);
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

endmodule

[src/mfs_skid.sv]
// Output register with a skid entry that absorbs one item under backpressure, after which the pipeline stalls.
module mfs_skid import mfs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  input  mfs_item_t        up_item,
  output logic             up_ready,
  mfs_out_if.source        out_ch
);

  logic      out_v_r, out_v_nxt;
  logic      sk_v_r, sk_v_nxt;
  mfs_item_t out_r, out_nxt;
  mfs_item_t sk_r, sk_nxt;

  always_comb begin
    out_v_nxt = out_v_r;
    sk_v_nxt  = sk_v_r;
    out_nxt   = out_r;
    sk_nxt    = sk_r;
    if (out_v_r && !out_ch.ready) begin
      if (up_valid && !sk_v_r) begin
        sk_v_nxt = 1'b1;
        sk_nxt   = up_item;
      end
    end else if (sk_v_r) begin
      out_v_nxt = 1'b1;
      out_nxt   = sk_r;
      sk_v_nxt  = 1'b0;
    end else begin
      out_v_nxt = up_valid;
      out_nxt   = up_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    sk_r  <= sk_nxt;
  end

  assign up_ready         = !sk_v_r;
  assign out_ch.valid     = out_v_r;
  assign out_ch.out_x     = out_r.x;
  assign out_ch.out_y     = out_r.y;
  assign out_ch.out_z     = out_r.z;
  assign out_ch.out_w     = out_r.w;
  assign out_ch.out_deriv = out_r.deriv;

endmodule

[src/menger_4d_fold_step_unit.sv]
// Top level of the 4D Menger fold step unit: config registers and pipeline.
//
// Takes one point per clock and returns one folded point per clock while the z
// divider is idle and the skid entry is free; an item passes through 6 fold
// stages, 5 sphere radius and factor stages, the divider stages with one
// quotient bit per step, and the sphere and skid output registers. The z fold
// plane comes from a serial divider that retires one bit per cycle, so after
// reset and every configuration write in_ch.ready stays low while recomputing.
`include "menger_4d_fold_step_unit_macros.svh"
module menger_4d_fold_step_unit import mfs_pkg::*; #(
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mfs_in_if.sink                in_ch,
  mfs_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int T_W = P_W + FRACTION_BITS;

  mfs_cfg_t       cfg_r, cfg_nxt;
  logic           busy;
  logic [T_W-1:0] t;
  logic           pipe_en;
  logic           accept;
  mfs_item_t      in_item;
  logic           fold_v, sph_v;
  mfs_item_t      fold_item, sph_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCALE:     cfg_nxt.scale          = cfg_data[SCALE_W-1:0];
        CFG_OFFSET_X:  cfg_nxt.offset_x       = cfg_data[P_W-1:0];
        CFG_OFFSET_Y:  cfg_nxt.offset_y       = cfg_data[P_W-1:0];
        CFG_OFFSET_Z:  cfg_nxt.offset_z       = cfg_data[P_W-1:0];
        CFG_OFFSET_W:  cfg_nxt.offset_w       = cfg_data[P_W-1:0];
        CFG_MIN_RSQ:   cfg_nxt.min_radius_sq  = cfg_data[RSQ_W-1:0];
        CFG_MAX_RSQ:   cfg_nxt.max_radius_sq  = cfg_data[RSQ_W-1:0];
        CFG_SPHERE_ON: cfg_nxt.sphere_fold_on = cfg_data[0];
        default:       cfg_nxt                = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{scale: SCALE_RST, offset_x: OFFSET_X_RST, offset_y: OFFSET_Y_RST,
                 offset_z: OFFSET_Z_RST, offset_w: OFFSET_W_RST,
                 min_radius_sq: MIN_RSQ_RST, max_radius_sq: MAX_RSQ_RST,
                 sphere_fold_on: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mfs_tdiv #(.FRACTION_BITS(FRACTION_BITS)) u_tdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (cfg_we),
    .scale    (cfg_r.scale),
    .offset_z (cfg_r.offset_z),
    .busy     (busy),
    .t        (t)
  );

  assign in_ch.ready = pipe_en && !busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_item     = '{x: in_ch.in_x, y: in_ch.in_y, z: in_ch.in_z, w: in_ch.in_w,
                         deriv: in_ch.in_deriv};

  mfs_fold #(.FRACTION_BITS(FRACTION_BITS)) u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (accept),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .t         (t),
    .out_valid (fold_v),
    .out_item  (fold_item)
  );

  mfs_sphere #(.FRACTION_BITS(FRACTION_BITS)) u_sphere (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (fold_v),
    .in_item   (fold_item),
    .cfg       (cfg_r),
    .out_valid (sph_v),
    .out_item  (sph_item)
  );

  mfs_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sph_v),
    .up_item  (sph_item),
    .up_ready (pipe_en),
    .out_ch   (out_ch)
  );

  `MFS_ASSERT_NEXT(a_cfg_blocks_input, clk, rst_n, cfg_we, !in_ch.ready)
  `MFS_ASSERT_IMPLY(a_no_beat_while_busy, clk, rst_n, busy, !accept)
  `MFS_ASSERT_NEXT(a_stall_holds_tail, clk, rst_n, sph_v && !pipe_en, sph_v)

endmodule
